// File: rtl/core/hsvrgb_pkg.sv
// Shared types and constants for the HSV to RGB converter.
// No dependencies.
package hsvrgb_pkg;

  // Default fixed point fraction width (ONE = 2**FRAC_BITS).
  localparam int unsigned FRAC_BITS_DEF = 16;

  // Hue sector after hue*6.
  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_e;

  // Control that travels down the pipeline with each transaction.
  typedef struct packed {
    logic    valid;
    sector_e sector;
  } pipe_ctl_t;

endpackage

// File: rtl/core/hsvrgb_sector.sv
// First pipeline stage: hue wrap, hue*6 sector split, clamping of s and v.
// Depends on hsvrgb_pkg.
module hsvrgb_sector #(
  parameter int unsigned FracBits = hsvrgb_pkg::FRAC_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  logic [FracBits:0]      hue_i,
  input  logic [FracBits:0]      sat_i,
  input  logic [FracBits:0]      val_i,
  output hsvrgb_pkg::pipe_ctl_t  ctl_o,
  output logic [FracBits:0]      sat_o,
  output logic [FracBits:0]      val_o,
  output logic [FracBits:0]      frac_o,
  output logic [FracBits:0]      one_minus_frac_o
);

  localparam int unsigned W = FracBits + 1;
  localparam logic [W-1:0] One = W'(1) << FracBits;

  logic [FracBits-1:0] hue_wrap;
  logic [FracBits+2:0] hue6;
  logic [W-1:0]        frac;
  logic [W-1:0]        sat_cl;
  logic [W-1:0]        val_cl;

  hsvrgb_pkg::pipe_ctl_t ctl_d, ctl_q;
  logic [W-1:0] sat_q, val_q, frac_q, omf_q;

  // Bit of weight ONE dropped: hue wraps modulo one turn.
  assign hue_wrap = hue_i[FracBits-1:0];
  // hue*6 as (hue<<2) + (hue<<1)
  assign hue6 = ({1'b0, hue_wrap, 2'b00} + {2'b00, hue_wrap, 1'b0});
  assign frac = {1'b0, hue6[FracBits-1:0]};
  assign sat_cl = (sat_i > One) ? One : sat_i;
  assign val_cl = (val_i > One) ? One : val_i;

  always_comb begin
    ctl_d.valid  = valid_i;
    ctl_d.sector = hsvrgb_pkg::sector_e'(hue6[FracBits+2:FracBits]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sat_q  <= sat_cl;
    val_q  <= val_cl;
    frac_q <= frac;
    omf_q  <= One - frac;
  end

  assign ctl_o            = ctl_q;
  assign sat_o            = sat_q;
  assign val_o            = val_q;
  assign frac_o           = frac_q;
  assign one_minus_frac_o = omf_q;

endmodule

// File: rtl/core/hsvrgb_fxmul.sv
// Registered fixed point multiply: (a*b) >> FracBits, truncated.
// Depends on hsvrgb_pkg for the default fraction width.
module hsvrgb_fxmul #(
  parameter int unsigned FracBits = hsvrgb_pkg::FRAC_BITS_DEF
) (
  input  logic              clk_i,
  input  logic [FracBits:0] a_i,
  input  logic [FracBits:0] b_i,
  output logic [FracBits:0] prod_o
);

  localparam int unsigned W = FracBits + 1;

  logic [2*W-1:0] prod_full;
  logic [W-1:0]   prod_q;

  assign prod_full = a_i * b_i;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_full[FracBits+W-1:FracBits];
  end

  assign prod_o = prod_q;

endmodule

// File: rtl/core/hsvrgb_route.sv
// Output stage: routes v, p, q, t to red/green/blue by sector and registers them.
// Depends on hsvrgb_pkg.
module hsvrgb_route #(
  parameter int unsigned FracBits = hsvrgb_pkg::FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  hsvrgb_pkg::pipe_ctl_t ctl_i,
  input  logic [FracBits:0]     val_i,
  input  logic [FracBits:0]     p_i,
  input  logic [FracBits:0]     q_i,
  input  logic [FracBits:0]     t_i,
  output logic                  valid_o,
  output logic [FracBits:0]     red_o,
  output logic [FracBits:0]     green_o,
  output logic [FracBits:0]     blue_o
);

  localparam int unsigned W = FracBits + 1;

  logic [W-1:0] red_d, green_d, blue_d;
  logic [W-1:0] red_q, green_q, blue_q;
  logic         valid_q;

  always_comb begin
    unique case (ctl_i.sector)
      hsvrgb_pkg::SEC_RED_YEL: begin
        red_d = val_i; green_d = t_i;   blue_d = p_i;
      end
      hsvrgb_pkg::SEC_YEL_GRN: begin
        red_d = q_i;   green_d = val_i; blue_d = p_i;
      end
      hsvrgb_pkg::SEC_GRN_CYN: begin
        red_d = p_i;   green_d = val_i; blue_d = t_i;
      end
      hsvrgb_pkg::SEC_CYN_BLU: begin
        red_d = p_i;   green_d = q_i;   blue_d = val_i;
      end
      hsvrgb_pkg::SEC_BLU_MAG: begin
        red_d = t_i;   green_d = p_i;   blue_d = val_i;
      end
      default: begin
        red_d = val_i; green_d = p_i;   blue_d = q_i;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    red_q   <= red_d;
    green_q <= green_d;
    blue_q  <= blue_d;
  end

  assign valid_o = valid_q;
  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;

endmodule

// File: rtl/core/hsv_to_rgb_converter.sv
// Top level of the HSV to RGB pixel converter.
// Depends on hsvrgb_pkg, hsvrgb_sector, hsvrgb_fxmul and hsvrgb_route.
//
// Usage:
//   A transaction is accepted at a rising edge where start_i is high and
//   busy_o is low. busy_o is tied low: the pipeline takes one pixel every
//   clock, so a new transaction may follow in each cycle.
//   All fields are unsigned fixed point, ONE = 2**FRAC_BITS, FRAC_BITS+1 bits.
//   Hue wraps modulo one turn; saturation and brightness clamp to ONE.
//   The result appears on red_o/green_o/blue_o for exactly one cycle with
//   done_o high, once the transaction has passed all four register stages.
//   Pipeline (one register stage each):
//     1. hue*6 -> sector and fraction f, clamp s and v
//     2. s*f and s*(1-f), plus 1-s
//     3. p = v(1-s), q = v(1-sf), t = v(1-s(1-f))
//     4. sector routing into the output registers
//   Every stage holds at most one multiplier per product path.
//   Zero saturation needs no special path: p, q and t all reduce to v.
//   Throughput: one transaction per clock. Each transaction passes the four
//   register stages in order; two of the four stages are the dependent
//   multiplies. The receiver cannot stall; results are presented once and
//   never held. Reset clears all valid bits, so no stray done_o pulse
//   follows reset; payload registers are not reset.
module hsv_to_rgb_converter #(
  parameter int unsigned FRAC_BITS = hsvrgb_pkg::FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [FRAC_BITS:0] hue_i,
  input  logic [FRAC_BITS:0] saturation_i,
  input  logic [FRAC_BITS:0] brightness_i,
  output logic               done_o,
  output logic [FRAC_BITS:0] red_o,
  output logic [FRAC_BITS:0] green_o,
  output logic [FRAC_BITS:0] blue_o
);

  localparam int unsigned W = FRAC_BITS + 1;
  localparam logic [W-1:0] One = W'(1) << FRAC_BITS;

  // stage 1 outputs
  hsvrgb_pkg::pipe_ctl_t ctl1;
  logic [W-1:0] sat1, val1, frac1, omf1;

  // stage 2
  hsvrgb_pkg::pipe_ctl_t ctl2_q;
  logic [W-1:0] val2_q, omsat2_q;
  logic [W-1:0] sf2, somf2;

  // stage 3
  hsvrgb_pkg::pipe_ctl_t ctl3_q;
  logic [W-1:0] val3_q;
  logic [W-1:0] p3, q3, t3;

  assign busy_o = 1'b0;

  hsvrgb_sector #(.FracBits(FRAC_BITS)) u_sector (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .valid_i          (start_i),
    .hue_i            (hue_i),
    .sat_i            (saturation_i),
    .val_i            (brightness_i),
    .ctl_o            (ctl1),
    .sat_o            (sat1),
    .val_o            (val1),
    .frac_o           (frac1),
    .one_minus_frac_o (omf1)
  );

  // Stage 2: s*f and s*(1-f)
  hsvrgb_fxmul #(.FracBits(FRAC_BITS)) u_mul_sf (
    .clk_i  (clk_i),
    .a_i    (sat1),
    .b_i    (frac1),
    .prod_o (sf2)
  );

  hsvrgb_fxmul #(.FracBits(FRAC_BITS)) u_mul_somf (
    .clk_i  (clk_i),
    .a_i    (sat1),
    .b_i    (omf1),
    .prod_o (somf2)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl2_q <= '0;
      ctl3_q <= '0;
    end else begin
      ctl2_q <= ctl1;
      ctl3_q <= ctl2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    val2_q   <= val1;
    omsat2_q <= One - sat1;
    val3_q   <= val2_q;
  end

  // Stage 3: scale by v
  hsvrgb_fxmul #(.FracBits(FRAC_BITS)) u_mul_p (
    .clk_i  (clk_i),
    .a_i    (val2_q),
    .b_i    (omsat2_q),
    .prod_o (p3)
  );

  hsvrgb_fxmul #(.FracBits(FRAC_BITS)) u_mul_q (
    .clk_i  (clk_i),
    .a_i    (val2_q),
    .b_i    (One - sf2),
    .prod_o (q3)
  );

  hsvrgb_fxmul #(.FracBits(FRAC_BITS)) u_mul_t (
    .clk_i  (clk_i),
    .a_i    (val2_q),
    .b_i    (One - somf2),
    .prod_o (t3)
  );

  // Stage 4: sector routing and output registers
  hsvrgb_route #(.FracBits(FRAC_BITS)) u_route (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl3_q),
    .val_i   (val3_q),
    .p_i     (p3),
    .q_i     (q3),
    .t_i     (t3),
    .valid_o (done_o),
    .red_o   (red_o),
    .green_o (green_o),
    .blue_o  (blue_o)
  );

endmodule
